// ----- design/sbi_pkg.sv -----
// sbi_pkg: widths, constants and pipeline types for the segment/box hit test.
// Used by every module of the design; no dependencies.
`default_nettype none
package sbi_pkg;
  localparam int CW = 32;          // coordinate width, Q16.16
  localparam int FB = 16;          // fraction bits
  localparam int XW = CW + 1;      // shifted endpoint width
  localparam int DW = CW + 2;      // difference width
  localparam int NW = DW + FB;     // numerator / quotient width
  localparam int PW = CW + DW;     // slope product width
  localparam int YW = PW - FB + 1; // y value width

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                 hit_x;
    logic                 vert;
    logic                 neg;
    logic signed [XW-1:0] ya;
    logic signed [XW-1:0] yb;
    logic signed [DW-1:0] rlo;
    logic signed [DW-1:0] rhi;
  } side_t;

  typedef struct packed {
    logic          vld;
    logic [DW-1:0] rem;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    side_t         side;
  } div_t;
endpackage
`default_nettype wire

// ----- design/sbi_div_cell.sv -----
// sbi_div_cell: one restoring division step, one quotient bit per cell.
// Depends on sbi_pkg.
`default_nettype none
module sbi_div_cell import sbi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire div_t d_i,
  output div_t      d_o
);
  div_t          d_r;
  logic [DW:0]   tmp;
  logic          ge;

  always_comb begin
    tmp = {d_i.rem, d_i.num[NW-1]};
    ge  = (tmp >= {1'b0, d_i.den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_i.vld;
    end
    if (en) begin
      d_r.rem  <= ge ? DW'(tmp - {1'b0, d_i.den}) : tmp[DW-1:0];
      d_r.num  <= {d_i.num[NW-2:0], ge};
      d_r.den  <= d_i.den;
      d_r.side <= d_i.side;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// ----- design/sbi_slope_eval.sv -----
// sbi_slope_eval: slope clamp, y evaluation at clipped x ends, y-span test.
// Depends on sbi_pkg; fed by the last division cell.
`default_nettype none
module sbi_slope_eval import sbi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire div_t                 d_i,
  input  wire logic signed [CW-1:0] rect_top,
  input  wire logic signed [CW-1:0] rect_bottom,
  output logic                      vld_o,
  output logic                      hit_o
);
  localparam logic [NW-1:0] LIM = NW'(1) << (CW-1);

  logic signed [CW-1:0] a;
  logic signed [PW-1:0] pl_r, ph_r;
  side_t                s_r;
  logic                 m_vld_r;
  logic                 vld_r, hit_r;
  logic signed [PW-1:0] shl, shh;
  logic signed [YW-1:0] ylo, yhi, lo, hi, top_e, bot_e;

  always_comb begin
    if (d_i.side.neg) begin
      a = (d_i.num > LIM) ? $signed(CW'(LIM)) : $signed(CW'(-d_i.num));
    end else begin
      a = (d_i.num >= LIM) ? $signed(CW'(LIM - NW'(1))) : $signed(d_i.num[CW-1:0]);
    end
  end

  always_comb begin
    shl   = pl_r >>> FB;
    shh   = ph_r >>> FB;
    top_e = YW'(rect_top);
    bot_e = YW'(rect_bottom);
    if (s_r.vert) begin
      ylo = YW'(s_r.ya);
      yhi = YW'(s_r.yb);
    end else begin
      ylo = YW'(s_r.ya) + shl[YW-1:0];
      yhi = YW'(s_r.ya) + shh[YW-1:0];
    end
    lo = (ylo > yhi) ? yhi : ylo;
    hi = (ylo > yhi) ? ylo : yhi;
    if (hi > bot_e) hi = bot_e;
    if (lo < top_e) lo = top_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      m_vld_r <= d_i.vld;
      vld_r   <= m_vld_r;
    end
    if (en) begin
      pl_r  <= a * d_i.side.rlo;
      ph_r  <= a * d_i.side.rhi;
      s_r   <= d_i.side;
      hit_r <= s_r.hit_x && !(lo > hi);
    end
  end

  assign vld_o = vld_r;
  assign hit_o = hit_r;
endmodule
`default_nettype wire

// ----- design/segment_box_intersect.sv -----
// Segment versus box hit test: input sums, x clip, division cell chain, y test.
// One item per cycle while no result waits at the output.
// The division runs in the 50-cell restoring divider, one quotient bit per cell.
// The whole pipeline holds while a result waits; in_ready = !out_valid | out_ready.
// Synchronous active-low reset clears valid bits and box registers to zero.
`default_nettype none
module segment_box_intersect import sbi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [CW-1:0] in_seg_start_x,
  input  wire logic signed [CW-1:0] in_seg_start_y,
  input  wire logic signed [CW-1:0] in_seg_end_x,
  input  wire logic signed [CW-1:0] in_seg_end_y,
  input  wire logic signed [CW-1:0] in_offset_x,
  input  wire logic signed [CW-1:0] in_offset_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_hit,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic signed [CW-1:0] cfg_data
);
  logic signed [CW-1:0] left_r, top_r, right_r, bottom_r;
  logic                 en;
  logic                 a_vld_r;
  logic signed [XW-1:0] xa_r, ya_r, xb_r, yb_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [XW-1:0] lo_x, hi_x, lft_e, rgt_e;
  div_t                 chain [0:NW];
  logic                 vld_q, hit_q;
  logic                 out_valid_r, out_hit_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT:   left_r   <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
    if (en) begin
      xa_r <= XW'(in_seg_start_x) + XW'(in_offset_x);
      ya_r <= XW'(in_seg_start_y) + XW'(in_offset_y);
      xb_r <= XW'(in_seg_end_x) + XW'(in_offset_x);
      yb_r <= XW'(in_seg_end_y) + XW'(in_offset_y);
      dx_r <= DW'(in_seg_end_x) - DW'(in_seg_start_x);
      dy_r <= DW'(in_seg_end_y) - DW'(in_seg_start_y);
    end
  end

  always_comb begin
    lft_e = XW'(left_r);
    rgt_e = XW'(right_r);
    lo_x  = (xa_r > xb_r) ? xb_r : xa_r;
    hi_x  = (xa_r > xb_r) ? xa_r : xb_r;
    if (hi_x > rgt_e) hi_x = rgt_e;
    if (lo_x < lft_e) lo_x = lft_e;
    chain[0].vld        = a_vld_r;
    chain[0].rem        = '0;
    chain[0].den        = dx_r[DW-1] ? DW'(-dx_r) : dx_r;
    chain[0].num        = {(dy_r[DW-1] ? DW'(-dy_r) : dy_r), {FB{1'b0}}};
    chain[0].side.hit_x = !(lo_x > hi_x);
    chain[0].side.vert  = (dx_r == '0);
    chain[0].side.neg   = dx_r[DW-1] ^ dy_r[DW-1];
    chain[0].side.ya    = ya_r;
    chain[0].side.yb    = yb_r;
    chain[0].side.rlo   = DW'(lo_x) - DW'(xa_r);
    chain[0].side.rhi   = DW'(hi_x) - DW'(xa_r);
  end

  for (genvar i = 0; i < NW; i++) begin : g_cell
    sbi_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  sbi_slope_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .d_i         (chain[NW]),
    .rect_top    (top_r),
    .rect_bottom (bottom_r),
    .vld_o       (vld_q),
    .hit_o       (hit_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_q;
    end
    if (en) begin
      out_hit_r <= hit_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
endmodule
`default_nettype wire

// ----- design/sbi_checker.sv -----
// sbi_checker: port-level assertions for segment_box_intersect, bound to the top.
// Depends on sbi_pkg.
`default_nettype none
module sbi_checker import sbi_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_hit
);
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result side");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("result changed while stalled");
endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_hit   (out_hit)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for segment_box_intersect (segment vs box hit test).
// Drives segments and box writes from a queue and checks every hit bit against an
// in-bench predictor. Depends on design/sbi_pkg.sv and design/segment_box_intersect.sv.
`timescale 1ns / 1ps
module tb_top;
  import sbi_pkg::*;

  localparam longint SAT64     = 64'h7fff_ffff_ffff_ffff;
  localparam longint ONE       = 65536;
  localparam int     DRAIN_CYC = 70;
  localparam int     LATE_ITEM = 1550;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, ox, oy;
  } seg_t;

  typedef struct {
    bit                   is_cfg;
    reg_idx_t             idx;
    logic signed [CW-1:0] data;
    seg_t                 seg;
  } op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_seg_start_x = '0, in_seg_start_y = '0;
  logic signed [CW-1:0] in_seg_end_x = '0, in_seg_end_y = '0;
  logic signed [CW-1:0] in_offset_x = '0, in_offset_y = '0;
  logic out_valid, out_hit;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic signed [CW-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  segment_box_intersect dut (.*);

  op_t    pending_ops[$];
  bit     hit_expected[$];
  longint box_l, box_t, box_r, box_b;
  int     n_sent, n_checked, n_hits, n_errors, n_cfg;
  int     send_gap, quiet_cyc;
  seg_t   cur_seg;

  function automatic longint mul_sat(longint a, longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    if (p > SAT64) return SAT64;
    if (p < -SAT64) return -SAT64;
    return p[63:0];
  endfunction

  function automatic bit predict_hit(seg_t s);
    longint xa, ya, xb, yb, lox, hix, loy, hiy, dx, dy, slope, t;
    xa = longint'(s.sx) + longint'(s.ox);
    ya = longint'(s.sy) + longint'(s.oy);
    xb = longint'(s.ex) + longint'(s.ox);
    yb = longint'(s.ey) + longint'(s.oy);
    lox = (xa > xb) ? xb : xa;
    hix = (xa > xb) ? xa : xb;
    loy = ya;
    hiy = yb;
    if (hix > box_r) hix = box_r;
    if (lox < box_l) lox = box_l;
    if (lox > hix) return 1'b0;
    dx = xb - xa;
    if (dx != 0) begin
      dy = yb - ya;
      slope = (dy * ONE) / dx;
      if (slope > 64'sd2147483647) slope = 64'sd2147483647;
      if (slope < -64'sd2147483648) slope = -64'sd2147483648;
      loy = ya + (mul_sat(slope, lox - xa) >>> FB);
      hiy = ya + (mul_sat(slope, hix - xa) >>> FB);
    end
    if (loy > hiy) begin
      t = loy; loy = hiy; hiy = t;
    end
    if (hiy > box_b) hiy = box_b;
    if (loy < box_t) loy = box_t;
    return loy <= hiy;
  endfunction

  function automatic logic signed [CW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[CW-1:0];
  endfunction

  // value around [lo, hi], spilling a quarter span either side
  function automatic logic signed [CW-1:0] near_span(longint lo, longint hi);
    longint a, b, span, r;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 4 * ONE;
    r = {$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff;
    return clamp32(a - span / 4 + r % (span + span / 2));
  endfunction

  function automatic seg_t rand_seg(longint l, longint t, longint r, longint b);
    seg_t s;
    int   kind;
    kind = $urandom_range(0, 99);
    s.sx = near_span(l, r);
    s.sy = near_span(t, b);
    s.ex = near_span(l, r);
    s.ey = near_span(t, b);
    s.ox = ($urandom_range(0, 2) == 0) ? $signed($urandom_range(0, 8 * ONE)) - 4 * ONE : 0;
    s.oy = ($urandom_range(0, 2) == 0) ? $signed($urandom_range(0, 8 * ONE)) - 4 * ONE : 0;
    if (kind < 20) begin
      s.sx = $urandom; s.sy = $urandom; s.ex = $urandom; s.ey = $urandom;
      s.ox = $urandom; s.oy = $urandom;
    end else if (kind < 32) begin
      s.ex = s.sx;
    end else if (kind < 40) begin
      s.ex = s.sx + $signed($urandom_range(0, 2)) - 1;
    end else if (kind < 46) begin
      s.ey = s.sy;
    end
    return s;
  endfunction

  task automatic push_box(longint l, longint t, longint r, longint b);
    op_t o;
    o.is_cfg = 1'b1;
    o.data = '0;
    o.seg = '{default: '0};
    o.idx = REG_LEFT;   o.data = clamp32(l); pending_ops.push_back(o);
    o.idx = REG_TOP;    o.data = clamp32(t); pending_ops.push_back(o);
    o.idx = REG_RIGHT;  o.data = clamp32(r); pending_ops.push_back(o);
    o.idx = REG_BOTTOM; o.data = clamp32(b); pending_ops.push_back(o);
  endtask

  task automatic push_seg(longint sx, longint sy, longint ex, longint ey,
                          longint ox, longint oy);
    op_t o;
    o.is_cfg = 1'b0;
    o.idx = REG_LEFT;
    o.data = '0;
    o.seg.sx = clamp32(sx); o.seg.sy = clamp32(sy);
    o.seg.ex = clamp32(ex); o.seg.ey = clamp32(ey);
    o.seg.ox = clamp32(ox); o.seg.oy = clamp32(oy);
    pending_ops.push_back(o);
  endtask

  task automatic push_random(longint l, longint t, longint r, longint b, int n);
    op_t o;
    o.is_cfg = 1'b0;
    o.idx = REG_LEFT;
    o.data = '0;
    repeat (n) begin
      o.seg = rand_seg(l, t, r, b);
      pending_ops.push_back(o);
    end
  endtask

  // driver: inputs and box writes; box writes only once the pipe has drained
  always @(posedge clk) begin
    bit   nv, ncv, in_done, cfg_done;
    op_t  o;
    nv = in_valid;
    ncv = cfg_valid;
    in_done = in_valid && in_ready;
    cfg_done = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (in_done) begin
        hit_expected.push_back(predict_hit(cur_seg));
        n_sent++;
        nv = 1'b0;
      end
      if (cfg_done) begin
        case (reg_idx_t'(cfg_index))
          REG_LEFT:   box_l = cfg_data;
          REG_TOP:    box_t = cfg_data;
          REG_RIGHT:  box_r = cfg_data;
          REG_BOTTOM: box_b = cfg_data;
        endcase
        n_cfg++;
        ncv = 1'b0;
      end
      quiet_cyc = (hit_expected.size() == 0 && !nv) ? quiet_cyc + 1 : 0;
      if (!nv && !ncv && pending_ops.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!pending_ops[0].is_cfg) begin
          o = pending_ops.pop_front();
          cur_seg = o.seg;
          in_seg_start_x <= o.seg.sx; in_seg_start_y <= o.seg.sy;
          in_seg_end_x <= o.seg.ex;   in_seg_end_y <= o.seg.ey;
          in_offset_x <= o.seg.ox;    in_offset_y <= o.seg.oy;
          nv = 1'b1;
          if (n_sent < LATE_ITEM && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 12);
        end else if (quiet_cyc >= DRAIN_CYC) begin
          o = pending_ops.pop_front();
          cfg_index <= o.idx;
          cfg_data <= o.data;
          ncv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    cfg_valid <= ncv;
  end

  // receiver back-pressure, with one long hold-off to fill the pipe
  int  stall_cyc;
  bit  long_done;
  always @(posedge clk) begin
    if (stall_cyc > 0) begin
      stall_cyc--;
      out_ready <= 1'b0;
    end else if (!long_done && n_sent > 400) begin
      long_done = 1'b1;
      stall_cyc = 300;
      out_ready <= 1'b0;
    end else if (n_sent < LATE_ITEM && $urandom_range(0, 9) == 0) begin
      stall_cyc = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && out_ready) begin
      if (hit_expected.size() == 0) begin
        $error("unexpected transfer: hit=%0b", out_hit);
        n_errors++;
      end else begin
        want = hit_expected.pop_front();
        if (out_hit !== want) begin
          $error("hit mismatch: expected %0b actual %0b", want, out_hit);
          n_errors++;
        end
        n_checked++;
        if (want) n_hits++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("segment_box_intersect test failed");
    $finish;
  end

  initial begin
    longint l, t, r, b;
    box_l = 0; box_t = 0; box_r = 0; box_b = 0;
    // directed: box x in [-10, 20], y in [-5, 15]
    push_box(-10 * ONE, -5 * ONE, 20 * ONE, 15 * ONE);
    push_seg(-30 * ONE, 0, 30 * ONE, 0, 0, 0);
    push_seg(-30 * ONE, 0, -11 * ONE, 0, 0, 0);
    push_seg(21 * ONE, 0, 40 * ONE, 40 * ONE, 0, 0);
    push_seg(0, -30 * ONE, 0, 30 * ONE, 0, 0);
    push_seg(25 * ONE, -30 * ONE, 25 * ONE, 30 * ONE, 0, 0);
    push_seg(0, 20 * ONE, 0, 30 * ONE, 0, 0);
    push_seg(-20 * ONE, -5 * ONE, -10 * ONE, -5 * ONE, 0, 0);
    push_seg(20 * ONE, 15 * ONE, 30 * ONE, 25 * ONE, 0, 0);
    push_seg(-20 * ONE, 0, 0, 30 * ONE, 0, 0);
    push_seg(30 * ONE, 20 * ONE, -30 * ONE, -20 * ONE, 0, 0);
    push_seg(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 0, 0);
    push_seg(0, -32768 * ONE, 1, 32767 * ONE, 0, 0);
    push_seg(0, 32767 * ONE, 1, -32768 * ONE, 0, 0);
    push_seg(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 0, 0);
    push_seg(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
             64'sd2147483647, -64'sd2147483648);
    push_seg(0, 0, 0, 0, -64'sd2147483648, 64'sd2147483647);
    push_seg(-64'sd2147483648, 0, 64'sd2147483647, 0, 64'sd2147483647, 0);
    push_seg(30 * ONE, 30 * ONE, 40 * ONE, 40 * ONE, -30 * ONE, -30 * ONE);
    push_random(-10 * ONE, -5 * ONE, 20 * ONE, 15 * ONE, 250);
    // x-inverted box, y-inverted box, then full-range box, then degenerate point box
    push_box(20 * ONE, -5 * ONE, -10 * ONE, 15 * ONE);
    push_random(-10 * ONE, -5 * ONE, 20 * ONE, 15 * ONE, 60);
    push_box(-10 * ONE, 15 * ONE, 20 * ONE, -5 * ONE);
    push_random(-10 * ONE, -5 * ONE, 20 * ONE, 15 * ONE, 60);
    push_box(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
    push_seg(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 0, 0);
    push_random(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 200);
    push_box(0, 0, 0, 0);
    push_seg(-ONE, -ONE, ONE, ONE, 0, 0);
    push_seg(-ONE, ONE, ONE, ONE, 0, 0);
    push_random(-ONE, -ONE, ONE, ONE, 150);
    repeat (5) begin
      l = $signed($urandom_range(0, 2000 * ONE)) - 1000 * ONE;
      t = $signed($urandom_range(0, 2000 * ONE)) - 1000 * ONE;
      r = l + $urandom_range(0, 500 * ONE);
      b = t + $urandom_range(0, 500 * ONE);
      push_box(l, t, r, b);
      push_random(l, t, r, b, 210);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !in_valid && !cfg_valid && hit_expected.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d segments (%0d hits) over %0d box register writes",
             n_checked, n_hits, n_cfg);
    if (n_errors == 0 && hit_expected.size() == 0) begin
      $display("segment_box_intersect test passed");
    end else begin
      $display("segment_box_intersect test failed");
    end
    $finish;
  end
endmodule

// ----- segment_box_intersect.f -----
design/sbi_pkg.sv
design/sbi_div_cell.sv
design/sbi_slope_eval.sv
design/segment_box_intersect.sv
design/sbi_checker.sv
tb/tb_top.sv
